// ===== hw/rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
package spq_pkg;

    localparam int unsigned DataWidth  = 32;
    localparam int unsigned CountWidth = 4;

    // Request commands.
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DEQUEUED = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic signed [DataWidth-1:0] EmptyValue = '1;

    typedef logic signed [DataWidth-1:0] t_word;

    // One queue slot as it moves between neighboring cells.
    typedef struct packed {
        logic  valid;
        t_word value;
        t_word prio;
    } t_slot;

    // Operation broadcast to every cell.
    typedef struct packed {
        logic  enq;
        logic  deq;
        t_word value;
        t_word prio;
    } t_ctrl;

endpackage

// ===== hw/rtl/spq_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted queue: compares its priority with the broadcast one
// and holds, loads the new pair, or shifts from a neighbor. Uses spq_pkg.
module spq_cell import spq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctrl i_ctrl,
    input  t_slot i_left,
    input  logic  i_left_keep,
    input  t_slot i_right,
    output t_slot o_slot,
    output logic  o_keep
);

    t_slot r_slot;
    t_slot n_slot;

    // A slot keeps its place on enqueue when it is occupied and its priority
    // number is not above the new one; these slots form a prefix of the row.
    assign o_keep = r_slot.valid && !(r_slot.prio > i_ctrl.prio);
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctrl.enq) begin
            if (o_keep) begin
                n_slot = r_slot;
            end else if (i_left_keep) begin
                n_slot.valid = 1'b1;
                n_slot.value = i_ctrl.value;
                n_slot.prio  = i_ctrl.prio;
            end else begin
                n_slot = i_left;
            end
        end else if (i_ctrl.deq) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot.value <= n_slot.value;
        r_slot.prio  <= n_slot.prio;
    end

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// Sorted priority queue built as a row of compare-and-shift cells.
// The result of a request is registered and appears on the output in the cycle after it is accepted.
// Throughput: one request per cycle while o_stall is low; every cell decides locally.
// Reset clears the slot valid bits, the entry count and the output valid flag;
// slot contents are not cleared. Uses spq_pkg and spq_cell.
module sorted_priority_queue import spq_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_command,
    input  logic signed [31:0]    i_item_value,
    input  logic signed [31:0]    i_item_priority,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_status,
    output logic signed [31:0]    o_out_value,
    output logic [3:0]            o_entry_count
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_slot                  w_slot [QUEUE_DEPTH];
    logic                   w_keep [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid;
    t_ctrl                  w_ctrl;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [1:0]    n_status;
    t_word         r_out_value;
    t_word         n_out_value;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = w_valid[QUEUE_DEPTH-1];
    assign w_empty  = !w_valid[0];

    assign w_ctrl.enq   = w_accept && (i_command == CMD_ENQUEUE) && !w_full;
    assign w_ctrl.deq   = w_accept && (i_command == CMD_DEQUEUE) && !w_empty;
    assign w_ctrl.value = i_item_value;
    assign w_ctrl.prio  = i_item_priority;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_slot w_left;
        logic  w_left_keep;
        t_slot w_right;

        if (g == 0) begin : g_head
            assign w_left      = '0;
            assign w_left_keep = 1'b1;
        end else begin : g_body
            assign w_left      = w_slot[g-1];
            assign w_left_keep = w_keep[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_slot[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_left      (w_left),
            .i_left_keep (w_left_keep),
            .i_right     (w_right),
            .o_slot      (w_slot[g]),
            .o_keep      (w_keep[g])
        );

        assign w_valid[g] = w_slot[g].valid;
    end

    always_comb begin
        n_count     = r_count;
        n_status    = ST_ENQUEUED;
        n_out_value = '0;
        if (i_command == CMD_ENQUEUE) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else begin
            if (w_empty) begin
                n_status    = ST_EMPTY;
                n_out_value = EmptyValue;
            end else begin
                n_status    = ST_DEQUEUED;
                n_out_value = w_slot[0].value;
                n_count     = r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_out_value <= n_out_value;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_out_value   = r_out_value;
    assign o_entry_count = CountWidth'(r_count);

`ifndef SYNTHESIS
    // The occupied slots always form a prefix starting at the queue front.
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + QUEUE_DEPTH'(1)) & w_valid) == '0)
        else $error("queue slots are not packed at the front");

    // The count tracks the occupied slots.
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("entry count disagrees with occupied slots");

    // A dequeue on a non-empty queue reports the front value.
    a_deq_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command == CMD_DEQUEUE && !w_empty)
        |=> (o_valid && o_status == ST_DEQUEUED
             && o_out_value == $past(w_slot[0].value)))
        else $error("dequeue did not return the front entry");
`endif

endmodule
